// File: src/bcm3_pkg.sv
// ============================================================================
// bcm3_pkg - shared types and constants for the border-clipped 3x3 median
// Field widths, window layout, configuration register indexes, reset values.
// ============================================================================
package bcm3_pkg;

  localparam int PIX_W  = 8;   // window pixel width
  localparam int POS_W  = 12;  // centre column / row width
  localparam int CFG_W  = 13;  // image width / height register width
  localparam int WIN_N  = 9;   // pixels in a full window
  localparam int RANK_W = 4;   // rank of one pixel inside the window, 0..8

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CFG_W-1:0]  side_t;
  typedef logic [RANK_W-1:0] rank_t;

  // Window slot order: row-major, top-left first.
  typedef pix_t [WIN_N-1:0] window_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  localparam side_t IMAGE_WIDTH_RST  = side_t'(256);
  localparam side_t IMAGE_HEIGHT_RST = side_t'(256);

  // Which window slots take part and which two ranks bound the middle.
  typedef struct packed {
    logic [WIN_N-1:0] used;
    rank_t            rank_lo;
    rank_t            rank_hi;
  } win_sel_t;

endpackage

// File: src/bcm3_pix_if.sv
// ============================================================================
// bcm3_pix_if - window input channel
// Carries the nine window pixels and the centre position with valid/ready.
// ============================================================================
interface bcm3_pix_if;
  import bcm3_pkg::*;

  logic valid;
  logic ready;
  pix_t pix_up_left;
  pix_t pix_up;
  pix_t pix_up_right;
  pix_t pix_left;
  pix_t pix_centre;
  pix_t pix_right;
  pix_t pix_down_left;
  pix_t pix_down;
  pix_t pix_down_right;
  pos_t centre_column;
  pos_t centre_row;

  modport source (
    output valid, pix_up_left, pix_up, pix_up_right, pix_left, pix_centre,
           pix_right, pix_down_left, pix_down, pix_down_right,
           centre_column, centre_row,
    input  ready
  );

  modport sink (
    input  valid, pix_up_left, pix_up, pix_up_right, pix_left, pix_centre,
           pix_right, pix_down_left, pix_down, pix_down_right,
           centre_column, centre_row,
    output ready
  );

endinterface

// File: src/bcm3_med_if.sv
// ============================================================================
// bcm3_med_if - median result channel
// Carries one filtered pixel with valid/ready.
// ============================================================================
interface bcm3_med_if;
  import bcm3_pkg::*;

  logic valid;
  logic ready;
  pix_t median_value;

  modport source (output valid, median_value, input ready);
  modport sink   (input valid, median_value, output ready);

endinterface

// File: src/bcm3_cfg_if.sv
// ============================================================================
// bcm3_cfg_if - configuration write channel
// Carries a register index and write data with valid/ready.
// ============================================================================
interface bcm3_cfg_if;
  import bcm3_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  side_t      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

// File: src/bcm3_border.sv
// ============================================================================
// bcm3_border - border classification
// Marks the window slots inside the image and picks the middle ranks.
// ============================================================================
module bcm3_border #(
  parameter int MAX_SIDE = 4096
) (
  input  bcm3_pkg::pos_t     centre_column,
  input  bcm3_pkg::pos_t     centre_row,
  input  bcm3_pkg::side_t    image_width,
  input  bcm3_pkg::side_t    image_height,
  output bcm3_pkg::win_sel_t sel
);
  import bcm3_pkg::*;

  localparam int SIDE_W = (CFG_W > $clog2(MAX_SIDE + 1)) ? CFG_W : $clog2(MAX_SIDE + 1);
  localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

  logic [SIDE_W-1:0] eff_width;
  logic [SIDE_W-1:0] eff_height;
  logic              col_first;
  logic              row_first;
  logic              col_last;
  logic              row_last;
  logic [2:0]        col_en;
  logic [2:0]        row_en;

  // Clamp oversized dimensions.
  assign eff_width  = (SIDE_W'(image_width) > MAX_SIDE_V) ? MAX_SIDE_V
                                                          : SIDE_W'(image_width);
  assign eff_height = (SIDE_W'(image_height) > MAX_SIDE_V) ? MAX_SIDE_V
                                                           : SIDE_W'(image_height);

  assign col_first = (centre_column == '0);
  assign row_first = (centre_row == '0);
  assign col_last  = ((SIDE_W'(centre_column) + SIDE_W'(1)) == eff_width);
  assign row_last  = ((SIDE_W'(centre_row) + SIDE_W'(1)) == eff_height);

  // Left / top edge wins over right / bottom edge.
  assign col_en = {col_first | ~col_last, 1'b1, ~col_first};
  assign row_en = {row_first | ~row_last, 1'b1, ~row_first};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sel.used[r * 3 + c] = row_en[r] & col_en[c];
      end
    end
    // Nine samples: middle rank 4; six: ranks 2 and 3; four: ranks 1 and 2.
    unique case ({&row_en, &col_en})
      2'b11: begin
        sel.rank_lo = rank_t'(4);
        sel.rank_hi = rank_t'(4);
      end
      2'b10, 2'b01: begin
        sel.rank_lo = rank_t'(2);
        sel.rank_hi = rank_t'(3);
      end
      default: begin
        sel.rank_lo = rank_t'(1);
        sel.rank_hi = rank_t'(2);
      end
    endcase
  end

endmodule

// File: src/bcm3_rank_select.sv
// ============================================================================
// bcm3_rank_select - rank-based median selection
// Ranks the used window pixels and averages the two middle ones.
// ============================================================================
module bcm3_rank_select (
  input  bcm3_pkg::window_t  win,
  input  bcm3_pkg::win_sel_t sel,
  output bcm3_pkg::pix_t     median
);
  import bcm3_pkg::*;

  rank_t        rank [WIN_N];
  pix_t         lo_val;
  pix_t         hi_val;
  logic [PIX_W:0] sum;

  // Rank = number of used pixels ordered ahead; ties broken by slot index.
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_N; j++) begin
        if (j != i && sel.used[j] &&
            (win[j] < win[i] || (win[j] == win[i] && j < i))) begin
          rank[i] = rank[i] + rank_t'(1);
        end
      end
    end
  end

  // Used ranks form a permutation, so exactly one slot matches each rank.
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (sel.used[i] && rank[i] == sel.rank_lo) begin
        lo_val = lo_val | win[i];
      end
      if (sel.used[i] && rank[i] == sel.rank_hi) begin
        hi_val = hi_val | win[i];
      end
    end
  end

  assign sum    = {1'b0, lo_val} + {1'b0, hi_val};
  assign median = sum[PIX_W:1];

endmodule

// File: src/border_clipped_median_3x3.sv
// ============================================================================
// border_clipped_median_3x3 - 3x3 median filter clipped at the image border
// Median of the in-image window pixels, mean of the middle pair when even.
// ============================================================================
// Takes one item per clock while the result side is not stalled and returns
// one median per item, in order, through the input register, then the
// result register. The rate is set by the combinational rank network: 72
// pixel compares feed nine rank counters, and the two middle ranks are
// picked and averaged before the result register. Corner centres use four
// samples, edge centres six and interior centres nine; column 0 and row 0
// win over the right and bottom edges, and image_width / image_height above
// MAX_SIDE act as MAX_SIDE. Configuration writes are always taken and must
// be made while the block holds no item.
// ============================================================================
module border_clipped_median_3x3 #(
  parameter int MAX_SIDE = 4096
) (
  input  logic        clk,
  input  logic        rst,
  bcm3_cfg_if.sink    cfg_in,
  bcm3_pix_if.sink    pix_in,
  bcm3_med_if.source  med_out
);
  import bcm3_pkg::*;

  // Configuration registers.
  side_t    image_width;
  side_t    image_height;

  // Input register stage.
  logic     s1_valid;
  window_t  s1_win;
  pos_t     s1_col;
  pos_t     s1_row;

  // Result register stage.
  logic     out_valid;
  pix_t     median_value;

  logic     out_load;
  logic     out_free;
  win_sel_t sel;
  pix_t     median_next;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, write the addressed register.
  // ---------------------------------------------------------------------------
  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_in.valid) begin
      unique case (cfg_in.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_in.data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_in.data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register frees when empty or taken; the input
  // register advances whenever the result register frees, so a waiting
  // result still leaves room for one more item.
  // ---------------------------------------------------------------------------
  assign out_free     = ~out_valid | med_out.ready;
  assign out_load     = s1_valid & out_free;
  assign pix_in.ready = ~s1_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pix_in.ready) begin
        s1_valid <= pix_in.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Capture the window, row-major from top-left.
  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.ready) begin
      s1_win <= {pix_in.pix_down_right, pix_in.pix_down, pix_in.pix_down_left,
                 pix_in.pix_right, pix_in.pix_centre, pix_in.pix_left,
                 pix_in.pix_up_right, pix_in.pix_up, pix_in.pix_up_left};
      s1_col <= pix_in.centre_column;
      s1_row <= pix_in.centre_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Median datapath between the two registers.
  // ---------------------------------------------------------------------------
  bcm3_border #(
    .MAX_SIDE (MAX_SIDE)
  ) u_border (
    .centre_column (s1_col),
    .centre_row    (s1_row),
    .image_width   (image_width),
    .image_height  (image_height),
    .sel           (sel)
  );

  bcm3_rank_select u_rank_select (
    .win    (s1_win),
    .sel    (sel),
    .median (median_next)
  );

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      median_value <= median_next;
    end
  end

  assign med_out.valid        = out_valid;
  assign med_out.median_value = median_value;

`ifndef SYNTHESIS
  // An accepted item always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> s1_valid)
    else $error("accepted item not held in input register");

  // A held item is not lost while the result side is stalled.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_col) && $stable(s1_row))
    else $error("input register lost an item under stall");

  // The window always clips to four, six or nine samples.
  a_sample_count: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($countones(sel.used) == 4 || $countones(sel.used) == 6 ||
                  $countones(sel.used) == 9))
    else $error("bad sample count");

  // The upper middle rank is half the sample count.
  a_mid_rank: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (32'(sel.rank_hi) == ($countones(sel.used) / 2)))
    else $error("middle rank does not match sample count");
`endif

endmodule
